// File: hdl/fomm_pkg.sv
// ----------------------------------------------------------------------------
// fomm_pkg
// Shared types, constants and the CORDIC arctangent table of the mixer.
// ----------------------------------------------------------------------------
package fomm_pkg;

	localparam int TRIG_FRACTION_BITS_DEF = 15;
	localparam int CORDIC_ITERATIONS_DEF  = 16;
	localparam int ATAN_LEN               = 24;
	localparam int FULL_TURN_CDEG         = 36000;
	localparam int HALF_TURN_CDEG         = 18000;
	localparam logic [31:0] CORDIC_GAIN_Q30 = 32'h26DD3B6A;

	localparam logic [0:0] ADDR_FIELD_ORIENTED = 1'b0;
	localparam logic [0:0] ADDR_HEADING_OFFSET = 1'b1;

	// Front-to-back transaction
	typedef struct packed {
		logic signed [15:0] vx;
		logic signed [15:0] vy;
		logic signed [15:0] turn;
		logic signed [16:0] diff;
		logic               rot;
	} cmd_t;

	function automatic logic signed [33:0] atan_entry(input int i);
		logic signed [33:0] r;
		r = '0;
		case (i)
			0:  r = 34'sh20000000;
			1:  r = 34'sh12E4051E;
			2:  r = 34'sh09FB385B;
			3:  r = 34'sh051111D4;
			4:  r = 34'sh028B0D43;
			5:  r = 34'sh0145D7E1;
			6:  r = 34'sh00A2F61E;
			7:  r = 34'sh00517C55;
			8:  r = 34'sh0028BE53;
			9:  r = 34'sh00145F2F;
			10: r = 34'sh000A2F98;
			11: r = 34'sh000517CC;
			12: r = 34'sh00028BE6;
			13: r = 34'sh000145F3;
			14: r = 34'sh0000A2FA;
			15: r = 34'sh0000517D;
			16: r = 34'sh000028BE;
			17: r = 34'sh0000145F;
			18: r = 34'sh00000A30;
			19: r = 34'sh00000518;
			20: r = 34'sh0000028C;
			21: r = 34'sh00000146;
			22: r = 34'sh000000A3;
			23: r = 34'sh00000051;
			default: r = '0;
		endcase
		return r;
	endfunction

endpackage

// File: hdl/fomm_front.sv
// ----------------------------------------------------------------------------
// fomm_front
// Accepts commands, forms the yaw difference and pushes them into a queue.
// ----------------------------------------------------------------------------
module fomm_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic signed [15:0]  velocity_x,
	input  logic signed [15:0]  velocity_y,
	input  logic signed [15:0]  turn_rate,
	input  logic signed [15:0]  yaw_angle,
	input  logic                field_oriented,
	input  logic signed [15:0]  heading_offset,
	input  logic                pop,
	output logic                q_valid,
	output fomm_pkg::cmd_t      q_head
);
	fomm_pkg::cmd_t slot_q [2];
	logic [1:0] cnt_q;
	logic       wr_q;
	logic       rd_q;
	fomm_pkg::cmd_t cmd;

	always_comb begin
		cmd.vx   = velocity_x;
		cmd.vy   = velocity_y;
		cmd.turn = turn_rate;
		cmd.diff = 17'(yaw_angle) - 17'(heading_offset);
		cmd.rot  = field_oriented;
	end

	// Back part pops every cycle, so two slots never overflow
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
		end else begin
			if (start) wr_q <= ~wr_q;
			if (pop && cnt_q != 2'd0) rd_q <= ~rd_q;
			cnt_q <= cnt_q + 2'(start) - 2'(pop && cnt_q != 2'd0);
		end
	end

	always_ff @(posedge clk) begin
		if (start) slot_q[wr_q] <= cmd;
	end

	assign q_valid = (cnt_q != 2'd0);
	assign q_head  = slot_q[rd_q];
endmodule

// File: hdl/fomm_back.sv
// ----------------------------------------------------------------------------
// fomm_back
// Pipelined angle reduction, unrolled CORDIC, rotation and wheel mixing.
// ----------------------------------------------------------------------------
module fomm_back #(
	parameter int TRIG_FRACTION_BITS = fomm_pkg::TRIG_FRACTION_BITS_DEF,
	parameter int CORDIC_ITERATIONS  = fomm_pkg::CORDIC_ITERATIONS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  fomm_pkg::cmd_t      in_cmd,
	output logic                out_valid,
	output logic signed [15:0]  w1,
	output logic signed [15:0]  w2,
	output logic signed [15:0]  w3,
	output logic signed [15:0]  w4,
	output logic                sat
);
	localparam int F  = TRIG_FRACTION_BITS;
	localparam int N  = CORDIC_ITERATIONS;
	localparam int CW = F + 4;
	localparam logic signed [CW-1:0] ONE = CW'(64'sd1 <<< F);
	localparam logic signed [CW-1:0] K0 =
		CW'((64'(fomm_pkg::CORDIC_GAIN_Q30) + (64'd1 << (29 - F))) >> (30 - F));
	localparam logic [47:0] RECIP = 48'(((64'd1 << 47) + 64'd35999) / 64'd36000);

	// s1: wrap to [0, 35999]
	logic        v_s1;
	logic [15:0] u_s1;
	fomm_pkg::cmd_t c_s1;
	logic signed [17:0] dw;
	always_comb begin
		dw = 18'(in_cmd.diff);
		if (dw < 0) dw = dw + 18'sd36000;
		if (dw < 0) dw = dw + 18'sd36000;
		if (dw >= 18'sd36000) dw = dw - 18'sd36000;
	end
	always_ff @(posedge clk) begin
		u_s1 <= 16'(dw);
		c_s1 <= in_cmd;
	end

	// s2: a = floor((u*2^32+18000)/36000) = floor(u*2^32/36000 + 0.5)
	// via reciprocal, then exact correction in s3
	logic        v_s2;
	logic [47:0] num_s2;
	logic [32:0] qe_s2;
	fomm_pkg::cmd_t c_s2;
	logic [63:0] pr;
	always_comb pr = 64'(u_s1) * 64'(RECIP);
	always_ff @(posedge clk) begin
		num_s2 <= {u_s1, 32'd0} + 48'd18000;
		qe_s2  <= 33'(pr >> 15);
		c_s2   <= c_s1;
	end

	logic        v_s3;
	logic signed [33:0] z_s3;
	logic        flip_s3;
	fomm_pkg::cmd_t c_s3;
	logic [32:0] q;
	logic [63:0] rem;
	logic signed [33:0] zz;
	logic fl;
	always_comb begin
		q = qe_s2;
		rem = 64'(num_s2) - 64'(q) * 64'd36000;
		if ($signed(rem) < 0) q = q - 33'd1;
		else if (rem >= 64'd36000) q = q + 33'd1;
		zz = {2'b00, q[31:0]};
		if (q[31]) zz = zz - 34'sh100000000;
		fl = 1'b0;
		if (zz > 34'sh40000000) begin zz = zz - 34'sh80000000; fl = 1'b1; end
		else if (zz < -34'sh40000000) begin zz = zz + 34'sh80000000; fl = 1'b1; end
	end
	always_ff @(posedge clk) begin
		z_s3 <= zz; flip_s3 <= fl; c_s3 <= c_s2;
	end

	// CORDIC stages
	logic signed [CW-1:0] cx [N+1];
	logic signed [CW-1:0] cy [N+1];
	logic signed [33:0]   cz [N+1];
	logic                 cf [N+1];
	logic                 cv [N+1];
	fomm_pkg::cmd_t       cc [N+1];
	assign cx[0] = K0;
	assign cy[0] = '0;
	assign cz[0] = z_s3;
	assign cf[0] = flip_s3;
	assign cv[0] = v_s3;
	assign cc[0] = c_s3;
	for (genvar i = 0; i < N; i++) begin : g_iter
		logic signed [CW-1:0] x_q, y_q;
		logic signed [33:0] z_q;
		logic f_q, v_q;
		fomm_pkg::cmd_t c_q;
		localparam logic signed [33:0] AT = (i < fomm_pkg::ATAN_LEN) ?
			fomm_pkg::atan_entry(i) : 34'sd0;
		localparam int SH = (i < fomm_pkg::ATAN_LEN) ? i : CW - 1;
		always_ff @(posedge clk) begin
			if (i >= fomm_pkg::ATAN_LEN) begin
				x_q <= cx[i]; y_q <= cy[i]; z_q <= cz[i];
			end else if (cz[i] >= 0) begin
				x_q <= cx[i] - (cy[i] >>> SH);
				y_q <= cy[i] + (cx[i] >>> SH);
				z_q <= cz[i] - AT;
			end else begin
				x_q <= cx[i] + (cy[i] >>> SH);
				y_q <= cy[i] - (cx[i] >>> SH);
				z_q <= cz[i] + AT;
			end
			f_q <= cf[i]; c_q <= cc[i];
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) v_q <= 1'b0;
			else         v_q <= cv[i];
		end
		assign cx[i+1] = x_q; assign cy[i+1] = y_q; assign cz[i+1] = z_q;
		assign cf[i+1] = f_q; assign cv[i+1] = v_q; assign cc[i+1] = c_q;
	end

	// flip and clamp
	logic signed [CW-1:0] cs_s4, sn_s4;
	logic v_s4;
	fomm_pkg::cmd_t c_s4;
	logic signed [CW-1:0] xc, yc;
	always_comb begin
		xc = cf[N] ? -cx[N] : cx[N];
		yc = cf[N] ? -cy[N] : cy[N];
		if (xc > ONE) xc = ONE;
		if (xc < -ONE) xc = -ONE;
		if (yc > ONE) yc = ONE;
		if (yc < -ONE) yc = -ONE;
	end
	always_ff @(posedge clk) begin
		cs_s4 <= xc; sn_s4 <= yc; c_s4 <= cc[N];
	end

	// products
	localparam int PW = CW + 16;
	logic signed [PW-1:0] p_xc_s5, p_ys_s5, p_yc_s5, p_xs_s5;
	logic v_s5;
	fomm_pkg::cmd_t c_s5;
	always_ff @(posedge clk) begin
		p_xc_s5 <= PW'(c_s4.vx) * PW'(cs_s4);
		p_ys_s5 <= PW'(c_s4.vy) * PW'(sn_s4);
		p_yc_s5 <= PW'(c_s4.vy) * PW'(cs_s4);
		p_xs_s5 <= PW'(c_s4.vx) * PW'(sn_s4);
		c_s5 <= c_s4;
	end

	// sums and truncation toward zero
	logic signed [18:0] rx_s6, ry_s6;
	logic v_s6;
	logic signed [15:0] turn_s6;
	logic signed [PW:0] sa, sb, ta, tb;
	localparam logic signed [PW:0] BIAS = (PW+1)'((64'sd1 <<< F) - 1);
	always_comb begin
		sa = (PW+1)'(p_xc_s5) + (PW+1)'(p_ys_s5);
		sb = (PW+1)'(p_yc_s5) - (PW+1)'(p_xs_s5);
		ta = (sa < 0) ? sa + BIAS : sa;
		tb = (sb < 0) ? sb + BIAS : sb;
	end
	always_ff @(posedge clk) begin
		if (c_s5.rot) begin
			rx_s6 <= 19'(ta >>> F);
			ry_s6 <= 19'(tb >>> F);
		end else begin
			rx_s6 <= 19'(c_s5.vx);
			ry_s6 <= 19'(c_s5.vy);
		end
		turn_s6 <= c_s5.turn;
	end

	// mix and saturate
	function automatic logic signed [15:0] sat16(input logic signed [20:0] v);
		if (v > 21'sd32767) return 16'sh7FFF;
		if (v < -21'sd32768) return 16'sh8000;
		return 16'(v);
	endfunction
	logic signed [20:0] m1, m2, m3, m4;
	logic any;
	always_comb begin
		m1 = 21'(rx_s6) - 21'(ry_s6) + 21'(turn_s6);
		m2 = -21'(rx_s6) + 21'(ry_s6) + 21'(turn_s6);
		m3 = 21'(rx_s6) + 21'(ry_s6) + 21'(turn_s6);
		m4 = -21'(rx_s6) - 21'(ry_s6) + 21'(turn_s6);
		any = (m1 != 21'(sat16(m1))) || (m2 != 21'(sat16(m2))) ||
		      (m3 != 21'(sat16(m3))) || (m4 != 21'(sat16(m4)));
	end
	always_ff @(posedge clk) begin
		w1 <= sat16(m1); w2 <= sat16(m2); w3 <= sat16(m3); w4 <= sat16(m4);
		sat <= any;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0; v_s2 <= 1'b0; v_s3 <= 1'b0; v_s4 <= 1'b0;
			v_s5 <= 1'b0; v_s6 <= 1'b0; out_valid <= 1'b0;
		end else begin
			v_s1 <= in_valid; v_s2 <= v_s1; v_s3 <= v_s2; v_s4 <= cv[N];
			v_s5 <= v_s4; v_s6 <= v_s5; out_valid <= v_s6;
		end
	end
endmodule

// File: hdl/field_oriented_mecanum_mixer_unit.sv
// ----------------------------------------------------------------------------
// field_oriented_mecanum_mixer_unit
// Field-oriented mecanum wheel mixer with a CORDIC rotation pipeline.
// ----------------------------------------------------------------------------
// Usage: drive the command fields and pulse start; busy is always low, so a
// command is taken every cycle. Each command yields one transaction on the
// wheel*_drive and saturated_flag ports, marked by done for one cycle.
// Path: a command passes through the queue slot, three angle-reduction
// stages, one stage per CORDIC iteration, then the clamp, product, sum
// and mix registers; done is registered together with the wheel outputs.
// Throughput is one command per cycle.
// Registers over APB: 0x0 field_oriented, 0x4 heading_offset. Write them
// only while no command is in flight.
// Reset clears both registers and all valid flags; nothing is in flight.
// The receiver cannot stall: a result is present for exactly one cycle.
// ----------------------------------------------------------------------------
module field_oriented_mecanum_mixer_unit #(
	parameter int TRIG_FRACTION_BITS = fomm_pkg::TRIG_FRACTION_BITS_DEF,
	parameter int CORDIC_ITERATIONS  = fomm_pkg::CORDIC_ITERATIONS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  logic signed [15:0]  velocity_x,
	input  logic signed [15:0]  velocity_y,
	input  logic signed [15:0]  turn_rate,
	input  logic signed [15:0]  yaw_angle,
	output logic                done,
	output logic signed [15:0]  wheel1_drive,
	output logic signed [15:0]  wheel2_drive,
	output logic signed [15:0]  wheel3_drive,
	output logic signed [15:0]  wheel4_drive,
	output logic                saturated_flag,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [2:0]          paddr,
	input  logic [31:0]         pwdata,
	output logic [31:0]         prdata,
	output logic                pready
);
	logic               fo_q;
	logic signed [15:0] ho_q;
	logic               q_valid;
	fomm_pkg::cmd_t     q_head;
	logic               wr;

	assign busy   = 1'b0;
	assign pready = 1'b1;
	assign wr     = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fo_q <= 1'b0;
			ho_q <= '0;
		end else if (wr && paddr[1:0] == 2'b00) begin
			if (paddr[2] == fomm_pkg::ADDR_FIELD_ORIENTED) fo_q <= pwdata[0];
			else                                           ho_q <= pwdata[15:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (paddr[1:0] == 2'b00) begin
			if (paddr[2] == fomm_pkg::ADDR_HEADING_OFFSET) prdata = 32'(ho_q);
			else                                           prdata = {31'd0, fo_q};
		end
	end

	fomm_front u_front (
		.clk(clk), .arst_n(arst_n), .start(start),
		.velocity_x(velocity_x), .velocity_y(velocity_y),
		.turn_rate(turn_rate), .yaw_angle(yaw_angle),
		.field_oriented(fo_q), .heading_offset(ho_q),
		.pop(1'b1), .q_valid(q_valid), .q_head(q_head)
	);

	fomm_back #(
		.TRIG_FRACTION_BITS(TRIG_FRACTION_BITS),
		.CORDIC_ITERATIONS(CORDIC_ITERATIONS)
	) u_back (
		.clk(clk), .arst_n(arst_n), .in_valid(q_valid), .in_cmd(q_head),
		.out_valid(done), .w1(wheel1_drive), .w2(wheel2_drive),
		.w3(wheel3_drive), .w4(wheel4_drive), .sat(saturated_flag)
	);
endmodule
